// ===== rtl/grid_neighbor_similarity_index_macros.svh =====
// assertion macros shared by the similarity index rtl
`ifndef GRID_NEIGHBOR_SIMILARITY_INDEX_MACROS_SVH
`define GRID_NEIGHBOR_SIMILARITY_INDEX_MACROS_SVH

// same-cycle implication, checked out of reset
`define GNSI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gnsi same-cycle check failed");

// next-cycle implication, checked out of reset
`define GNSI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gnsi next-cycle check failed");

`endif

// ===== rtl/gnsi_pkg.sv =====
// shared widths, types, tables and helpers of the similarity index
`default_nettype none

package gnsi_pkg;

  localparam int MAX_SIDE = 64;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int POS_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int UNIT_DEN = 840;
  localparam int SUM_W    = $clog2(CELLS * UNIT_DEN + 1);
  localparam int RECIP_W  = $clog2(UNIT_DEN + 1);
  localparam int NCNT_W   = 4;
  localparam int PROD_W   = NCNT_W + RECIP_W;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 7;
  localparam int SIM_W    = 17;
  localparam int OCC_W    = 13;

  // cell codes
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_A     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_B     = 2'd2;

  // neighbor offsets, row then column
  localparam logic signed [1:0] NB_DR [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                              2'sd0, 2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] NB_DC [8] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1,
                                              2'sd1, -2'sd1, 2'sd0, 2'sd1};

  // pass totals handed to the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] tally;
  } gnsi_tot_t;

  // final quotient and occupied count
  typedef struct packed {
    logic [SIM_W-1:0] sim;
    logic [CNT_W-1:0] occ;
  } gnsi_res_t;

  // unknown code reads as empty
  function automatic logic [KIND_W-1:0] kind_norm(input logic [KIND_W-1:0] k);
    return (k == KIND_A || k == KIND_B) ? k : KIND_EMPTY;
  endfunction

  // 840 / n for n occupied neighbors, zero when none
  function automatic logic [RECIP_W-1:0] recip(input logic [NCNT_W-1:0] n);
    logic [RECIP_W-1:0] v;
    case (n)
      4'd1:    v = RECIP_W'(UNIT_DEN / 1);
      4'd2:    v = RECIP_W'(UNIT_DEN / 2);
      4'd3:    v = RECIP_W'(UNIT_DEN / 3);
      4'd4:    v = RECIP_W'(UNIT_DEN / 4);
      4'd5:    v = RECIP_W'(UNIT_DEN / 5);
      4'd6:    v = RECIP_W'(UNIT_DEN / 6);
      4'd7:    v = RECIP_W'(UNIT_DEN / 7);
      4'd8:    v = RECIP_W'(UNIT_DEN / 8);
      default: v = '0;
    endcase
    return v;
  endfunction

  // side register clamp: zero runs as one, oversize as the maximum
  function automatic logic [SIDE_W-1:0] side_clamp(input logic [CFG_W-1:0] v);
    logic [SIDE_W-1:0] s;
    if (v == '0) begin
      s = SIDE_W'(1);
    end else if (int'(v) > MAX_SIDE) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(v);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gnsi_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module gnsi_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/gnsi_scan.sv =====
// neighbor scan sequencer: walks the stored grid one ram read per cycle
`default_nettype none

module gnsi_scan
  import gnsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SIDE_W-1:0] side,
  output logic      [ADDR_W-1:0] rd_addr,
  input  wire logic [KIND_W-1:0] rd_data,
  output logic                   done,
  output gnsi_tot_t              tot
);

  localparam logic [2:0] SC_IDLE  = 3'd0;
  localparam logic [2:0] SC_SELF  = 3'd1;
  localparam logic [2:0] SC_SELFW = 3'd2;
  localparam logic [2:0] SC_NB    = 3'd3;
  localparam logic [2:0] SC_ACC   = 3'd4;
  localparam logic [2:0] SC_ADD   = 3'd5;
  localparam logic [2:0] SC_FIN   = 3'd6;

  logic [2:0]        st_r, st_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [NCNT_W-1:0] k_r, k_nxt;
  logic              ok_r, ok_nxt;
  logic [KIND_W-1:0] self_r, self_nxt;
  logic [NCNT_W-1:0] same_r, same_nxt;
  logic [NCNT_W-1:0] occn_r, occn_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  tally_r, tally_nxt;

  logic [POS_W-1:0]  side_m1;
  logic [2:0]        kidx;
  logic              dr_neg, dr_pos, dc_neg, dc_pos;
  logic [ADDR_W-1:0] side_a, row_off, col_off, nb_addr;
  logic              nb_inb;
  logic [KIND_W-1:0] rd_kind;
  logic              last_cell;

  // neighbor address and bounds for offset k
  always_comb begin
    side_m1 = POS_W'(side - SIDE_W'(1));
    kidx    = k_r[2:0];
    dr_neg  = (NB_DR[kidx] < 0);
    dr_pos  = (NB_DR[kidx] > 0);
    dc_neg  = (NB_DC[kidx] < 0);
    dc_pos  = (NB_DC[kidx] > 0);
    side_a  = ADDR_W'(side);
    row_off = dr_neg ? (~side_a + ADDR_W'(1)) : (dr_pos ? side_a : '0);
    col_off = dc_neg ? '1 : (dc_pos ? ADDR_W'(1) : '0);
    nb_addr = idx_r + row_off + col_off;
    nb_inb  = !(dr_neg && row_r == '0) && !(dr_pos && row_r == side_m1) &&
              !(dc_neg && col_r == '0) && !(dc_pos && col_r == side_m1);
    rd_kind   = kind_norm(rd_data);
    last_cell = (row_r == side_m1) && (col_r == side_m1);
  end

  assign rd_addr = (st_r == SC_NB) ? nb_addr : idx_r;

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    ok_nxt    = ok_r;
    self_nxt  = self_r;
    same_nxt  = same_r;
    occn_nxt  = occn_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    unique case (st_r)
      SC_IDLE: begin
        if (start) begin
          row_nxt   = '0;
          col_nxt   = '0;
          idx_nxt   = '0;
          sum_nxt   = '0;
          tally_nxt = '0;
          st_nxt    = SC_SELF;
        end
      end
      SC_SELF: begin
        st_nxt = SC_SELFW;
      end
      SC_SELFW: begin
        if (rd_kind != KIND_EMPTY) begin
          self_nxt  = rd_kind;
          tally_nxt = tally_r + CNT_W'(1);
          same_nxt  = '0;
          occn_nxt  = '0;
          k_nxt     = '0;
          ok_nxt    = 1'b0;
          st_nxt    = SC_NB;
        end else if (last_cell) begin
          st_nxt = SC_FIN;
        end else begin
          st_nxt  = SC_SELF;
          idx_nxt = idx_r + ADDR_W'(1);
          if (col_r == side_m1) begin
            col_nxt = '0;
            row_nxt = row_r + POS_W'(1);
          end else begin
            col_nxt = col_r + POS_W'(1);
          end
        end
      end
      SC_NB: begin
        // data of the previous offset arrives while the next is issued
        if (k_r != '0 && ok_r && rd_kind != KIND_EMPTY) begin
          occn_nxt = occn_r + NCNT_W'(1);
          if (rd_kind == self_r) begin
            same_nxt = same_r + NCNT_W'(1);
          end
        end
        ok_nxt = nb_inb;
        k_nxt  = k_r + NCNT_W'(1);
        if (k_r == NCNT_W'(8)) begin
          st_nxt = SC_ACC;
        end
      end
      SC_ACC: begin
        prod_nxt = PROD_W'(same_r) * PROD_W'(recip(occn_r));
        st_nxt   = SC_ADD;
      end
      SC_ADD: begin
        sum_nxt = sum_r + SUM_W'(prod_r);
        if (last_cell) begin
          st_nxt = SC_FIN;
        end else begin
          st_nxt  = SC_SELF;
          idx_nxt = idx_r + ADDR_W'(1);
          if (col_r == side_m1) begin
            col_nxt = '0;
            row_nxt = row_r + POS_W'(1);
          end else begin
            col_nxt = col_r + POS_W'(1);
          end
        end
      end
      SC_FIN: begin
        st_nxt = SC_IDLE;
      end
      default: begin
        st_nxt = SC_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SC_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    ok_r    <= ok_nxt;
    self_r  <= self_nxt;
    same_r  <= same_nxt;
    occn_r  <= occn_nxt;
    prod_r  <= prod_nxt;
    sum_r   <= sum_nxt;
    tally_r <= tally_nxt;
  end

  assign done      = (st_r == SC_FIN);
  assign tot.sum   = sum_r;
  assign tot.tally = tally_r;

endmodule

`default_nettype wire

// ===== rtl/gnsi_div.sv =====
// bit-serial restoring divider: floor(65536 * sum / (840 * tally))
`default_nettype none

module gnsi_div
  import gnsi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire gnsi_tot_t tot,
  input  wire logic      ack,
  output logic           done,
  output gnsi_res_t      res
);

  localparam int DEN_W  = SUM_W;
  localparam int STEP_W = $clog2(SIM_W);

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_MUL  = 2'd1;
  localparam logic [1:0] DV_RUN  = 2'd2;
  localparam logic [1:0] DV_DONE = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [SIM_W-1:0]  nb_r, nb_nxt;
  logic [SIM_W-1:0]  q_r, q_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  logic [DEN_W:0]    trial;
  logic              ge;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_r, nb_r[SIM_W-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  always_comb begin
    st_nxt  = st_r;
    sum_nxt = sum_r;
    occ_nxt = occ_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    nb_nxt  = nb_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      DV_IDLE: begin
        if (start) begin
          sum_nxt = tot.sum;
          occ_nxt = tot.tally;
          st_nxt  = DV_MUL;
        end
      end
      DV_MUL: begin
        // divisor is tally in units of 1/840; numerator is sum shifted by 16
        den_nxt = DEN_W'(occ_r) * DEN_W'(UNIT_DEN);
        rem_nxt = DEN_W'(sum_r >> 1);
        nb_nxt  = SIM_W'(sum_r[0]) << (SIM_W - 1);
        q_nxt   = '0;
        cnt_nxt = '0;
        st_nxt  = (occ_r == '0) ? DV_DONE : DV_RUN;
      end
      DV_RUN: begin
        rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        nb_nxt  = nb_r << 1;
        q_nxt   = {q_r[SIM_W-2:0], ge};
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(SIM_W - 1)) begin
          st_nxt = DV_DONE;
        end
      end
      DV_DONE: begin
        if (ack) begin
          st_nxt = DV_IDLE;
        end
      end
      default: begin
        st_nxt = DV_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    occ_r <= occ_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    nb_r  <= nb_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done    = (st_r == DV_DONE);
  assign res.sim = q_r;
  assign res.occ = occ_r;

endmodule

`default_nettype wire

// ===== rtl/grid_neighbor_similarity_index.sv =====
// top level: loads a grid cell per word, scans neighbors, then divides once
// load: one cell word per cycle while cfg_valid is low; no word taken in scan or divide
// scan: SELF, SELFW per cell, then NB, ACC, ADD if occupied; one ram read per cycle
// divide: MUL, RUN per quotient bit, then DONE loads the output register when it is free
// reset: synchronous active low; side returns to 64, load count clears, ram keeps its data
`default_nettype none

`include "grid_neighbor_similarity_index_macros.svh"

module grid_neighbor_similarity_index
  import gnsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KIND_W-1:0] in_cell_kind,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [SIM_W-1:0]  out_similarity_q16,
  output logic      [OCC_W-1:0]  out_occupied_cells,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_grid_side
);

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_SCAN = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic [SIDE_W-1:0] side_r, side_nxt;
  logic [CNT_W-1:0]  cells_loaded_r, cells_loaded_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SIM_W-1:0]  out_sim_r, out_sim_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;

  logic [CNT_W-1:0]  total;
  logic              cfg_wr, in_acc, last_in;
  logic              slot_free, div_ack;
  logic              scan_start, scan_done;
  logic [ADDR_W-1:0] rd_addr;
  logic [KIND_W-1:0] rd_data;
  gnsi_tot_t         tot;
  logic              div_done;
  gnsi_res_t         res;

  // handshakes; a side write holds off the cell word
  always_comb begin
    total     = CNT_W'(side_r) * CNT_W'(side_r);
    cfg_ready = (phase_r == PH_LOAD);
    in_stall  = (phase_r != PH_LOAD) || cfg_valid;
    cfg_wr    = cfg_valid && cfg_ready;
    in_acc    = in_valid && !in_stall;
    last_in   = in_acc && ((cells_loaded_r + CNT_W'(1)) == total);
    slot_free = !out_valid_r || !out_stall;
    div_ack   = div_done && slot_free && (phase_r == PH_DIV);
    scan_start = last_in;
  end

  // grid store
  gnsi_ram #(
    .WIDTH (KIND_W),
    .DEPTH (CELLS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (cells_loaded_r[ADDR_W-1:0]),
    .wr_data (in_cell_kind),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gnsi_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .side    (side_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (scan_done),
    .tot     (tot)
  );

  gnsi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_done),
    .tot   (tot),
    .ack   (div_ack),
    .done  (div_done),
    .res   (res)
  );

  // phase, side, load count and output word
  always_comb begin
    phase_nxt        = phase_r;
    side_nxt         = side_r;
    cells_loaded_nxt = cells_loaded_r;
    out_valid_nxt    = out_valid_r;
    out_sim_nxt      = out_sim_r;
    out_occ_nxt      = out_occ_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (phase_r)
      PH_LOAD: begin
        if (cfg_wr) begin
          side_nxt         = side_clamp(cfg_grid_side);
          cells_loaded_nxt = '0;
        end else if (last_in) begin
          cells_loaded_nxt = '0;
          phase_nxt        = PH_SCAN;
        end else if (in_acc) begin
          cells_loaded_nxt = cells_loaded_r + CNT_W'(1);
        end
      end
      PH_SCAN: begin
        if (scan_done) begin
          phase_nxt = PH_DIV;
        end
      end
      PH_DIV: begin
        if (div_ack) begin
          out_valid_nxt = 1'b1;
          out_sim_nxt   = res.sim;
          out_occ_nxt   = OCC_W'(res.occ);
          phase_nxt     = PH_LOAD;
        end
      end
      default: begin
        phase_nxt = PH_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LOAD;
      side_r         <= side_clamp(CFG_W'(64));
      cells_loaded_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      side_r         <= side_nxt;
      cells_loaded_r <= cells_loaded_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_sim_r <= out_sim_nxt;
    out_occ_r <= out_occ_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_similarity_q16 = out_sim_r;
  assign out_occupied_cells = out_occ_r;

  // checks
  `GNSI_ASSERT_IMP(a_load_in_range, in_acc, cells_loaded_r < total)
  `GNSI_ASSERT_IMP(a_scan_done_phase, scan_done, phase_r == PH_SCAN)
  `GNSI_ASSERT_NXT(a_result_bound, div_ack, out_similarity_q16 <= SIM_W'(65536))
  `GNSI_ASSERT_NXT(a_cfg_clears_load, cfg_wr, cells_loaded_r == '0)

endmodule

`default_nettype wire
